// File: src/csro_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csro_pkg: shared types and codes for the slot replacement order block
// Holds the command and status codes, the word layouts, the controller
// state type and the command struct from the controller to the datapath.
// ----------------------------------------------------------------------------
package csro_pkg;

  // Input word fields.
  localparam int unsigned CMD_W       = 1;
  localparam int unsigned TGT_W       = 4;
  localparam int unsigned MASK_W      = 16;
  localparam int unsigned IN_DATA_W   = 24;

  // Output word fields.
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned OUT_SLOT_W  = 4;
  localparam int unsigned USED_W      = 5;
  localparam int unsigned OUT_DATA_W  = 16;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_PROMOTE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_FRESH    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REUSED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_PROMOTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd4;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE
  } ctl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted input word
    logic scan;    // register the per-entry match flags
    logic commit;  // apply the list update and load the result register
  } ctl_cmd_t;

endpackage

// File: src/csro_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csro_ctrl: sequencing controller
// Accepts one input word, steps the datapath through its scan and update
// cycles and owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module csro_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output csro_pkg::ctl_cmd_t cmd_o
);
  import csro_pkg::*;

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  // An item may enter when idle and the output register is free or draining.
  assign s_tready_o = (state_q == S_IDLE) && (!out_valid_q || m_tready_i);
  assign accept     = s_tvalid_i && s_tready_o;
  assign m_tvalid_o = out_valid_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_SCAN;
      end
      S_SCAN:   state_d = S_UPDATE;
      S_UPDATE: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:   cmd_o.load   = accept;
      S_SCAN:   cmd_o.scan   = 1'b1;
      S_UPDATE: cmd_o.commit = 1'b1;
      default:  cmd_o = '0;
    endcase
  end

  // Output valid flag: set by a commit, cleared when the word is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: src/csro_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csro_dpath: replacement order datapath
// Holds the order list and the allocation count, computes one match flag
// per list entry, picks the first match and shifts or swaps the list.
// ----------------------------------------------------------------------------
module csro_dpath #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  csro_pkg::ctl_cmd_t                  cmd_i,
  input  logic [csro_pkg::IN_DATA_W-1:0]      in_data_i,
  output logic [csro_pkg::OUT_DATA_W-1:0]     out_data_o
);
  import csro_pkg::*;

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned EW = (SW > TGT_W) ? SW : TGT_W;
  localparam int unsigned TW = (CW > TGT_W) ? CW : TGT_W;

  // Captured input word.
  logic [CMD_W-1:0]  cmd_q;
  logic [TGT_W-1:0]  tgt_q;
  logic [MASK_W-1:0] mask_q;

  // Order list (entry 0 is the head) and allocation count.
  logic [SW-1:0]     list_q [SLOTS];
  logic [SW-1:0]     list_d [SLOTS];
  logic [CW-1:0]     count_q, count_d;

  // Scan results.
  logic [SLOTS-1:0]  flags_q, flags_d;
  logic              tgt_ok_q;

  // First match.
  logic [SW-1:0]     pos;
  logic              found;

  // Result fields.
  logic [STATUS_W-1:0]   res_status;
  logic [OUT_SLOT_W-1:0] res_slot;
  logic [STATUS_W-1:0]   status_q;
  logic [OUT_SLOT_W-1:0] slot_q;
  logic [USED_W-1:0]     used_q;

  // Input capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= in_data_i[0 +: CMD_W];
      tgt_q  <= in_data_i[CMD_W +: TGT_W];
      mask_q <= in_data_i[CMD_W + TGT_W +: MASK_W];
    end
  end

  // One flag per entry: the reusable test on allocate, the target match on
  // promote. Slots above fifteen have no busy bit and count as free.
  always_comb begin
    logic [EW-1:0] ext;
    for (int k = 0; k < SLOTS; k++) begin
      ext = EW'(list_q[k]);
      if (cmd_q == CMD_ALLOC) begin
        flags_d[k] = !(((ext >> TGT_W) == '0) && mask_q[ext[TGT_W-1:0]]);
      end else begin
        flags_d[k] = (ext == EW'(tgt_q)) && (CW'(k) < count_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan) begin
      flags_q  <= flags_d;
      tgt_ok_q <= TW'(tgt_q) < TW'(count_q);
    end
  end

  // Priority pick of the first flagged entry from the head.
  always_comb begin
    pos   = '0;
    found = 1'b0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (flags_q[k]) begin
        pos   = SW'(k);
        found = 1'b1;
      end
    end
  end

  // List update and result for the captured command.
  always_comb begin
    logic [SW-1:0] sel;
    list_d     = list_q;
    count_d    = count_q;
    res_status = ST_NONE;
    res_slot   = '0;
    sel        = list_q[pos];
    if (cmd_q == CMD_ALLOC) begin
      if (count_q < CW'(SLOTS)) begin
        // Hand out the next never-used slot at the tail.
        for (int k = 0; k < SLOTS; k++) begin
          if (CW'(k) == count_q) list_d[k] = SW'(k);
        end
        count_d    = count_q + CW'(1);
        res_status = ST_FRESH;
        res_slot   = OUT_SLOT_W'(count_q);
      end else if (found) begin
        // Close the gap behind the reused slot and put it at the tail.
        for (int k = 0; k < SLOTS - 1; k++) begin
          if (SW'(k) >= pos) list_d[k] = list_q[k + 1];
        end
        list_d[SLOTS-1] = sel;
        res_status      = ST_REUSED;
        res_slot        = OUT_SLOT_W'(sel);
      end
    end else begin
      res_slot = tgt_q;
      if (!tgt_ok_q || !found || ((CW'(pos) + CW'(1)) >= count_q)) begin
        res_status = ST_IGNORED;
      end else begin
        // Swap the target with its successor.
        for (int k = 0; k < SLOTS - 1; k++) begin
          if (SW'(k) == pos) list_d[k] = list_q[k + 1];
        end
        for (int k = 1; k < SLOTS; k++) begin
          if (CW'(k) == (CW'(pos) + CW'(1))) list_d[k] = SW'(tgt_q);
        end
        res_status = ST_PROMOTED;
      end
    end
  end

  // Order list and result payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      list_q   <= list_d;
      status_q <= res_status;
      slot_q   <= res_slot;
      used_q   <= USED_W'(count_d);
    end
  end

  // Allocation count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  assign out_data_o = {{(OUT_DATA_W - STATUS_W - OUT_SLOT_W - USED_W){1'b0}},
                       used_q, slot_q, status_q};

endmodule

// File: src/cache_slot_replacement_order_core.sv
`timescale 1ns / 1ps
// A result word passes through the capture, scan and update steps of the
// controller; a new input word is taken only once it is back in idle, with
// one item in flight at a time.
// Reset clears the allocation count and the controller; the order list needs
// no clearing pass, since only entries already written are ever read.
// ----------------------------------------------------------------------------
// cache_slot_replacement_order_core: cache slot replacement order
// Hands out fresh or reusable cache slots in replacement order and moves
// promoted slots one place toward the tail.
// ----------------------------------------------------------------------------
module cache_slot_replacement_order_core #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  output logic                             s_tready_o,
  // Fields from bit 0: command[0], target_slot[4:1], busy_mask[20:5].
  input  logic [csro_pkg::IN_DATA_W-1:0]   s_tdata_i,
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  // Fields from bit 0: status[2:0], slot_out[6:3], used_count[11:7].
  output logic [csro_pkg::OUT_DATA_W-1:0]  m_tdata_o
);
  import csro_pkg::*;

  ctl_cmd_t cmd;

  csro_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .cmd_o      (cmd)
  );

  csro_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (s_tdata_i),
    .out_data_o (m_tdata_o)
  );

endmodule
